### hw/rtl/jsu_pkg.sv
package jsu_pkg;

  // Saturation point of the byte and character counts
  localparam int unsigned MaxChars = 65535;
  localparam int unsigned CountW   = $clog2(MaxChars + 1);

  // Depth of the queue between the classifier and the decoder
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowerU = 8'h75;
  localparam logic [7:0] ChNul    = 8'h00;

  typedef enum logic [2:0] {
    StBusy    = 3'd0,
    StDone    = 3'd1,
    StBadEsc  = 3'd2,
    StBadHex  = 3'd3,
    StOver    = 3'd4,
    StEarly   = 3'd5,
    StNoQuote = 3'd6
  } status_e;

  // One classified input beat
  typedef struct packed {
    logic       first;
    logic       is_quote;
    logic       is_bslash;
    logic       is_nul;
    logic       is_u;
    logic       esc_ok;
    logic [7:0] esc_char;
    logic       hex_ok;
    logic [3:0] nibble;
    logic [7:0] raw;
  } item_t;

endpackage

### hw/rtl/jsu_front.sv
module jsu_front (
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              first_i,
  input  logic              push_ready_i,
  output logic              in_ready_o,
  output logic              push_valid_o,
  output jsu_pkg::item_t    push_item_o
);

  logic       esc_ok;
  logic [7:0] esc_char;
  logic       hex_ok;
  logic [3:0] nibble;

  // Map the single-letter escapes
  always_comb begin
    esc_ok   = 1'b1;
    esc_char = in_byte_i;
    unique case (in_byte_i)
      8'h22: esc_char = 8'h22;
      8'h5C: esc_char = 8'h5C;
      8'h2F: esc_char = 8'h2F;
      8'h62: esc_char = 8'h08;
      8'h66: esc_char = 8'h0C;
      8'h6E: esc_char = 8'h0A;
      8'h72: esc_char = 8'h0D;
      8'h74: esc_char = 8'h09;
      default: begin
        esc_ok   = 1'b0;
        esc_char = 8'h00;
      end
    endcase
  end

  // Hex digit in either case
  always_comb begin
    hex_ok = 1'b1;
    nibble = 4'h0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      nibble = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      nibble = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      nibble = 4'(in_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    push_item_o.first     = first_i;
    push_item_o.is_quote  = (in_byte_i == jsu_pkg::ChQuote);
    push_item_o.is_bslash = (in_byte_i == jsu_pkg::ChBslash);
    push_item_o.is_nul    = (in_byte_i == jsu_pkg::ChNul);
    push_item_o.is_u      = (in_byte_i == jsu_pkg::ChLowerU);
    push_item_o.esc_ok    = esc_ok;
    push_item_o.esc_char  = esc_char;
    push_item_o.hex_ok    = hex_ok;
    push_item_o.nibble    = nibble;
    push_item_o.raw       = in_byte_i;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

### hw/rtl/jsu_fifo.sv
module jsu_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  jsu_pkg::item_t  push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output jsu_pkg::item_t  pop_item_o,
  input  logic            pop_ready_i
);

  jsu_pkg::item_t                  mem_q [jsu_pkg::QDepth];
  logic [jsu_pkg::QPtrW-1:0]       wptr_q, wptr_d;
  logic [jsu_pkg::QPtrW-1:0]       rptr_q, rptr_d;
  logic [jsu_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            push, pop;

  assign push_ready_o = (cnt_q != jsu_pkg::QCntW'(jsu_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == jsu_pkg::QPtrW'(jsu_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == jsu_pkg::QPtrW'(jsu_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

### hw/rtl/jsu_back.sv
module jsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  input  jsu_pkg::item_t  pop_item_i,
  output logic            pop_ready_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_valid_o,
  output logic [2:0]      status_o,
  output logic [15:0]     consumed_o,
  output logic [15:0]     out_length_o
);

  localparam int unsigned CountW = jsu_pkg::CountW;
  localparam int unsigned ExtW   = CountW + 16;

  typedef enum logic [4:0] {
    PhIdle  = 5'b00001,
    PhPlain = 5'b00010,
    PhEsc   = 5'b00100,
    PhHex   = 5'b01000,
    PhHalt  = 5'b10000
  } phase_e;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    if (v >= CountW'(jsu_pkg::MaxChars)) begin
      return CountW'(jsu_pkg::MaxChars);
    end
    return v + 1'b1;
  endfunction

  function automatic logic [15:0] report(input logic [CountW-1:0] v);
    logic [ExtW-1:0] ext;
    ext = ExtW'(v);
    if (ext > ExtW'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return ext[15:0];
  endfunction

  phase_e              phase_q, phase_d;
  logic [11:0]         hex_q, hex_d;
  logic [1:0]          digits_q, digits_d;
  logic [CountW-1:0]   in_cnt_q, in_cnt_d;
  logic [CountW-1:0]   out_cnt_q, out_cnt_d;
  jsu_pkg::status_e    last_q, st;
  logic                emit;
  logic [7:0]          ob;
  logic                rvalid_q;
  logic                take;

  // Take a queued beat whenever the result register is free or being drained
  assign pop_ready_o = !rvalid_q || res_ready_i;
  assign take        = pop_valid_i && pop_ready_o;

  always_comb begin
    phase_d   = phase_q;
    hex_d     = hex_q;
    digits_d  = digits_q;
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    st        = last_q;
    emit      = 1'b0;
    ob        = 8'h00;
    if (pop_item_i.first) begin
      hex_d     = '0;
      digits_d  = '0;
      in_cnt_d  = '0;
      out_cnt_d = '0;
      if (pop_item_i.is_quote) begin
        in_cnt_d = CountW'(1);
        phase_d  = PhPlain;
        st       = jsu_pkg::StBusy;
      end else begin
        phase_d = PhHalt;
        st      = jsu_pkg::StNoQuote;
      end
    end else if (phase_q == PhPlain || phase_q == PhEsc || phase_q == PhHex) begin
      in_cnt_d = sat_inc(in_cnt_q);
      st       = jsu_pkg::StBusy;
      if (pop_item_i.is_nul) begin
        st = jsu_pkg::StEarly;
      end else begin
        unique case (phase_q)
          PhPlain: begin
            if (pop_item_i.is_quote) begin
              st = jsu_pkg::StDone;
            end else if (pop_item_i.is_bslash) begin
              phase_d = PhEsc;
            end else begin
              ob   = pop_item_i.raw;
              emit = 1'b1;
            end
          end
          PhEsc: begin
            phase_d = PhPlain;
            if (pop_item_i.esc_ok) begin
              ob   = pop_item_i.esc_char;
              emit = 1'b1;
            end else if (pop_item_i.is_u) begin
              phase_d  = PhHex;
              hex_d    = '0;
              digits_d = '0;
            end else begin
              st = jsu_pkg::StBadEsc;
            end
          end
          default: begin
            if (!pop_item_i.hex_ok) begin
              st = jsu_pkg::StBadHex;
            end else if (digits_q == 2'd3) begin
              // Fourth digit: the top byte of the value must be zero
              digits_d = '0;
              hex_d    = {hex_q[7:0], pop_item_i.nibble};
              if (hex_q[11:4] != 8'h00) begin
                st = jsu_pkg::StOver;
              end else begin
                ob      = {hex_q[3:0], pop_item_i.nibble};
                emit    = 1'b1;
                phase_d = PhPlain;
              end
            end else begin
              hex_d    = {hex_q[7:0], pop_item_i.nibble};
              digits_d = digits_q + 1'b1;
            end
          end
        endcase
      end
      if (st != jsu_pkg::StBusy) begin
        phase_d = PhHalt;
      end
      if (emit) begin
        out_cnt_d = sat_inc(out_cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      hex_q     <= '0;
      digits_q  <= '0;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      last_q    <= jsu_pkg::StBusy;
      rvalid_q  <= 1'b0;
    end else begin
      if (take) begin
        phase_q   <= phase_d;
        hex_q     <= hex_d;
        digits_q  <= digits_d;
        in_cnt_q  <= in_cnt_d;
        out_cnt_q <= out_cnt_d;
        last_q    <= st;
        rvalid_q  <= 1'b1;
      end else if (res_ready_i) begin
        rvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_o   <= ob;
      out_valid_o  <= emit;
      status_o     <= st;
      consumed_o   <= report(in_cnt_d);
      out_length_o <= report(out_cnt_d);
    end
  end

  assign res_valid_o = rvalid_q;

endmodule

### hw/rtl/json_string_unescape_decoder.sv
// Unescapes a quoted JSON string arriving one byte per beat, with first_i set on the
// opening quote. Every input beat yields exactly one result beat carrying the decoded
// byte (out_valid_o), the status (0 busy, 1 done, 2 bad escape, 3 bad hex, 4 \u value
// above 0xFF, 5 NUL before the closing quote, 6 no opening quote) and the byte and
// character counts, which saturate at 65535. After done or an error, beats are ignored
// until the next first_i. One byte is taken per cycle while the queue has room; a byte's
// result passes from the input into the two-entry classifier queue and from there into
// the decoder's result register before it appears on the result port. During an output
// stall the queue takes input until both its entries are full, then holds the input until
// after the stall ends, since a full queue takes no beat in the cycle it is popped.
module json_string_unescape_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        first_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] consumed_o,
  output logic [15:0] out_length_o
);

  logic           push_valid, push_ready;
  jsu_pkg::item_t push_item;
  logic           pop_valid, pop_ready;
  jsu_pkg::item_t pop_item;

  jsu_front u_front (
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .first_i      (first_i),
    .push_ready_i (push_ready),
    .in_ready_o   (in_ready_o),
    .push_valid_o (push_valid),
    .push_item_o  (push_item)
  );

  jsu_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_item_i   (pop_item),
    .pop_ready_o  (pop_ready),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_byte_o   (out_byte_o),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .consumed_o   (consumed_o),
    .out_length_o (out_length_o)
  );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned LimitCycles = 400_000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned ShowMax     = 10;
  localparam int unsigned DrainMax    = 5000;

  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowQ   = 8'h71;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;

  typedef enum logic [2:0] {PhIdle, PhPlain, PhEsc, PhHex, PhHalt} scan_phase_e;

  typedef struct packed {
    logic [7:0]        chr;
    logic              chr_valid;
    jsu_pkg::status_e  status;
    logic [15:0]       consumed;
    logic [15:0]       out_len;
  } decode_t;

  class unescape_scoreboard;
    scan_phase_e      scan;
    logic [15:0]      hex_acc;
    logic [2:0]       hex_cnt;
    int unsigned      byte_cnt;
    int unsigned      char_cnt;
    jsu_pkg::status_e last_st;
    decode_t          awaited[$];
    int               errors;

    function new();
      scan     = PhIdle;
      hex_acc  = '0;
      hex_cnt  = '0;
      byte_cnt = 0;
      char_cnt = 0;
      last_st  = jsu_pkg::StBusy;
      errors   = 0;
    endfunction

    function int nibble_of(logic [7:0] b);
      if (b >= ChDigit0 && b <= ChDigit9) return int'(b - ChDigit0);
      if (b >= ChLowA && b <= ChLowF) return int'(b - ChLowA) + 10;
      if (b >= ChUpA && b <= ChUpF) return int'(b - ChUpA) + 10;
      return -1;
    endfunction

    function int unsigned bump(int unsigned v);
      return (v >= jsu_pkg::MaxChars) ? jsu_pkg::MaxChars : v + 1;
    endfunction

    function logic [15:0] clip(int unsigned v);
      return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function bit empty();
      return awaited.size() == 0;
    endfunction

    // Advance the decoder by one accepted beat and queue its result.
    function void note_byte(logic [7:0] b, logic f);
      decode_t          d;
      logic [7:0]       ob;
      bit               emit;
      jsu_pkg::status_e st;
      int               nib;
      ob   = 8'h00;
      emit = 1'b0;
      st   = last_st;
      if (f) begin
        hex_acc  = '0;
        hex_cnt  = '0;
        byte_cnt = 0;
        char_cnt = 0;
        if (b == jsu_pkg::ChQuote) begin
          byte_cnt = 1;
          scan     = PhPlain;
          st       = jsu_pkg::StBusy;
        end else begin
          scan = PhHalt;
          st   = jsu_pkg::StNoQuote;
        end
      end else if (scan == PhPlain || scan == PhEsc || scan == PhHex) begin
        byte_cnt = bump(byte_cnt);
        st       = jsu_pkg::StBusy;
        if (b == jsu_pkg::ChNul) begin
          st = jsu_pkg::StEarly;
        end else if (scan == PhPlain) begin
          if (b == jsu_pkg::ChQuote) st = jsu_pkg::StDone;
          else if (b == jsu_pkg::ChBslash) scan = PhEsc;
          else begin
            ob   = b;
            emit = 1'b1;
          end
        end else if (scan == PhEsc) begin
          scan = PhPlain;
          emit = 1'b1;
          case (b)
            jsu_pkg::ChQuote, jsu_pkg::ChBslash, ChSlash: ob = b;
            ChLowB: ob = ChBs;
            ChLowF: ob = ChFf;
            ChLowN: ob = ChLf;
            ChLowR: ob = ChCr;
            ChLowT: ob = ChTab;
            jsu_pkg::ChLowerU: begin
              emit    = 1'b0;
              scan    = PhHex;
              hex_acc = '0;
              hex_cnt = '0;
            end
            default: begin
              emit = 1'b0;
              st   = jsu_pkg::StBadEsc;
            end
          endcase
        end else begin
          nib = nibble_of(b);
          if (nib < 0) begin
            st = jsu_pkg::StBadHex;
          end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            hex_cnt = hex_cnt + 3'd1;
            if (hex_cnt >= 3'd4) begin
              if (hex_acc > 16'h00FF) st = jsu_pkg::StOver;
              else begin
                ob   = hex_acc[7:0];
                emit = 1'b1;
                scan = PhPlain;
              end
              hex_cnt = '0;
            end
          end
        end
        if (st != jsu_pkg::StBusy) scan = PhHalt;
        if (emit) char_cnt = bump(char_cnt);
      end
      last_st     = st;
      d.chr       = emit ? ob : 8'h00;
      d.chr_valid = emit;
      d.status    = st;
      d.consumed  = clip(byte_cnt);
      d.out_len   = clip(char_cnt);
      awaited.push_back(d);
    endfunction

    function void check_result(decode_t got);
      decode_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= ShowMax) $display("unexpected result beat: byte %02h st %0d",
                                         got.chr, got.status);
        return;
      end
      want = awaited.pop_front();
      if (got.chr !== want.chr || got.chr_valid !== want.chr_valid ||
          got.status !== want.status || got.consumed !== want.consumed ||
          got.out_len !== want.out_len) begin
        errors++;
        if (errors <= ShowMax)
          $display({"mismatch: exp byte %02h v %0b st %0d cons %0d len %0d",
                    " | got byte %02h v %0b st %0d cons %0d len %0d"},
                   want.chr, want.chr_valid, want.status, want.consumed, want.out_len,
                   got.chr, got.chr_valid, got.status, got.consumed, got.out_len);
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i   = 8'h00;
  logic        first_i     = 1'b0;
  logic        res_valid_o;
  logic        res_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic [15:0] consumed_o;
  logic [15:0] out_length_o;

  unescape_scoreboard sb = new();

  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_left = 0;
  int unsigned counted   = 0;
  logic [7:0]  text_buf[$];

  json_string_unescape_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .first_i      (first_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_byte_o   (out_byte_o),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .consumed_o   (consumed_o),
    .out_length_o (out_length_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  initial begin
    #(LimitCycles * 2 * ClkHalf);
    $display("tb: errors");
    $finish;
  end

  // Result side: check accepted beats, then pick the next ready level.
  initial begin
    decode_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_valid_o && res_ready_i) begin
        got = '{chr: out_byte_o, chr_valid: out_valid_o,
                status: jsu_pkg::status_e'(status_o),
                consumed: consumed_o, out_len: out_length_o};
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        res_ready_i <= 1'b0;
        hold_left--;
      end else begin
        res_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic f);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    first_i    <= f;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, f);
  endtask

  task automatic send_text(input bit lead_first);
    foreach (text_buf[i]) send_byte(text_buf[i], lead_first && i == 0);
    text_buf.delete();
  endtask

  // Hold the input idle until every queued result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (!sb.empty());
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == jsu_pkg::ChQuote || b == jsu_pkg::ChBslash);
    return b;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return ChDigit0 + 8'(n);
    return ($urandom_range(1) ? ChLowA : ChUpA) + 8'(n) - 8'd10;
  endfunction

  task automatic push_unicode(input logic [15:0] v, input int unsigned ndigits);
    text_buf.push_back(jsu_pkg::ChBslash);
    text_buf.push_back(jsu_pkg::ChLowerU);
    for (int i = 0; i < ndigits; i++) text_buf.push_back(hex_char(v[15 - 4 * i -: 4]));
  endtask

  task automatic build_string();
    int unsigned segs;
    int unsigned pick;
    logic [7:0]  b;
    text_buf.push_back(jsu_pkg::ChQuote);
    segs = $urandom_range(0, 10);
    repeat (segs) begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        text_buf.push_back(plain_byte());
      end else if (pick < 8) begin
        text_buf.push_back(jsu_pkg::ChBslash);
        case ($urandom_range(7))
          0: b = jsu_pkg::ChQuote;
          1: b = jsu_pkg::ChBslash;
          2: b = ChSlash;
          3: b = ChLowB;
          4: b = ChLowF;
          5: b = ChLowN;
          6: b = ChLowR;
          default: b = ChLowT;
        endcase
        text_buf.push_back(b);
      end else begin
        push_unicode(16'($urandom_range(0, 255)), 4);
      end
    end
    if ($urandom_range(99) < 70) begin
      // leave some strings open so the next opening quote restarts mid-string
      if ($urandom_range(9) != 0) text_buf.push_back(jsu_pkg::ChQuote);
    end else begin
      case ($urandom_range(4))
        0: begin
          text_buf.push_back(jsu_pkg::ChBslash);
          do b = 8'($urandom);
          while (b == jsu_pkg::ChQuote || b == jsu_pkg::ChBslash || b == ChSlash ||
                 b == ChLowB || b == ChLowF || b == ChLowN || b == ChLowR ||
                 b == ChLowT || b == jsu_pkg::ChLowerU);
          text_buf.push_back(b);
        end
        1: begin
          push_unicode(16'($urandom), $urandom_range(0, 3));
          do b = 8'($urandom); while (sb.nibble_of(b) >= 0);
          text_buf.push_back(b);
        end
        2: push_unicode(16'($urandom_range(16'h0100, 16'hFFFF)), 4);
        3: text_buf.push_back(jsu_pkg::ChNul);
        default: begin
          if ($urandom_range(1)) text_buf.push_back(jsu_pkg::ChBslash);
          else push_unicode(16'($urandom), $urandom_range(0, 3));
          text_buf.push_back(jsu_pkg::ChNul);
        end
      endcase
    end
  endtask

  task automatic run_strings(input int unsigned goal);
    while (counted < goal) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom), $urandom_range(3) == 0);
      end else begin
        build_string();
        counted += text_buf.size();
        send_text(1'b1);
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 13;
    recv_idle = 63;

    // ignored before any string
    send_byte(ChLowX, 1'b0);
    // top plain byte, simple escape, mixed-case hex escape, close
    text_buf = {jsu_pkg::ChQuote, 8'hFF, jsu_pkg::ChBslash, ChLowN, jsu_pkg::ChBslash,
                jsu_pkg::ChLowerU, ChDigit0, ChDigit0, ChLowF, ChUpF, jsu_pkg::ChQuote};
    send_text(1'b1);
    send_byte(jsu_pkg::ChNul, 1'b0);
    send_byte(ChLowX, 1'b1);
    text_buf = {jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChNul};
    send_text(1'b1);
    text_buf = {jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChLowerU, ChDigit9,
                jsu_pkg::ChNul};
    send_text(1'b1);
    // restart mid-string, then a bad escape letter
    text_buf = {jsu_pkg::ChQuote, 8'h01};
    send_text(1'b1);
    text_buf = {jsu_pkg::ChQuote, jsu_pkg::ChBslash, ChLowQ};
    send_text(1'b1);

    run_strings(150);
    drain();

    send_idle = 63;
    recv_idle = 13;
    run_strings(300);
    drain();

    send_idle = 0;
    recv_idle = 0;
    // stall the result side long enough to back the block up into its input
    hold_left = HoldCycles;
    run_strings(450);

    // short string of escapes closed right after a hex escape
    send_byte(jsu_pkg::ChQuote, 1'b1);
    text_buf = {jsu_pkg::ChBslash, ChLowT};
    push_unicode(16'h0041, 4);
    text_buf.push_back(jsu_pkg::ChQuote);
    send_text(1'b0);

    in_valid_i <= 1'b0;
    waited = 0;
    while (!sb.empty() && waited < DrainMax) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (!sb.empty()) begin
      $display("%0d result beats never arrived", sb.awaited.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
